// ===== sv/tvmm_pkg.sv =====
package tvmm_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int WORD_W      = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CAP_W-1:0]  cap_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [1:0]        act_t;
    typedef logic [1:0]        stat_t;

    localparam act_t ACT_ADD         = 2'd0;
    localparam act_t ACT_SEARCH      = 2'd1;
    localparam act_t ACT_REMOVE_PAIR = 2'd2;
    localparam act_t ACT_REMOVE_KEY  = 2'd3;

    localparam stat_t ST_DONE = 2'd0;
    localparam stat_t ST_MISS = 2'd1;
    localparam stat_t ST_FULL = 2'd2;

    localparam cap_t CAP_RESET   = cap_t'(MAX_ENTRIES);
    localparam logic REG_CAPACITY = 1'b0;

endpackage

// ===== sv/two_value_multimap_table.sv =====
// two-value multimap table: a bounded store of key/value pairs, at most two
// values per key.
// input channel s_axis: one request item per handshake (add pair, search key,
// remove pair, remove key). output channel m_axis: exactly one result item per
// request, carrying status, up to two values, values found, entry count and
// the empty and full flags.
// apb port: register 0 at byte address 0 is capacity_limit (0 acts as 1,
// anything above the built depth acts as the depth).
// operation: each request walks the stored entries with one key/value
// comparator and a table with one read and one write port, each entry visited
// in a read state then a compare state; a removal moves the last entry into
// the hole through a move-read and a move-write state per deleted entry. the
// result becomes valid in the same cycle that the input is ready again; the
// longest request is a remove key deleting two entries of a full table. an
// add on a full table skips the walk. the input is not ready meanwhile.
// the result sits in an output register: the next request is accepted while
// it waits, and a stalled receiver only holds the block once a second result
// is finished.
// reset: the table is empty and capacity_limit is the built depth; the table
// contents need no clearing since only entries below the count are read.
module two_value_multimap_table
    import tvmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // action[1:0], key[33:2], value[65:34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // status[1:0], first_value[33:2],
                                       // second_value[65:34], values_found[67:66],
                                       // entry_count[72:68], is_empty[73], is_full[74]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_READ    = 3'd1;
    localparam logic [2:0] S_CMP     = 3'd2;
    localparam logic [2:0] S_MOVE_RD = 3'd3;
    localparam logic [2:0] S_MOVE_WR = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] state_reg, state_next;
    cap_t       cap_reg;
    cnt_t       count_reg, count_next;
    cnt_t       idx_reg, idx_next;
    logic [1:0] found_reg, found_next;
    stat_t      status_reg, status_next;
    act_t       act_reg, act_next;
    word_t      key_reg, key_next;
    word_t      val_reg, val_next;
    word_t      v1_reg, v1_next;
    word_t      v2_reg, v2_next;

    word_t      key_mem [MAX_ENTRIES];
    word_t      val_mem [MAX_ENTRIES];
    word_t      rd_key_reg, rd_val_reg;
    addr_t      rd_addr;
    logic       wr_en;
    addr_t      wr_addr;
    word_t      wr_key, wr_val;

    logic        out_valid_reg;
    logic [79:0] out_data_reg;
    logic        out_load;

    cnt_t  lim;
    logic  at_full;
    logic  key_hit, pair_hit;
    logic  cfg_wr;
    stat_t fin_status;
    logic  fin_found_used;

    // effective capacity limit
    always_comb
    begin
        if (cap_reg == '0)
            lim = cnt_t'(1);
        else if ({1'b0, cap_reg} > (CAP_W+1)'(MAX_ENTRIES))
            lim = cnt_t'(MAX_ENTRIES);
        else
            lim = cnt_t'(cap_reg);
    end

    assign at_full = (count_reg >= lim);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_wr)
            cap_reg <= pwdata[CAP_W-1:0];
    end

    // table memory, one write and one registered read per cycle
    assign rd_addr = (state_reg == S_MOVE_RD) ? addr_t'(count_reg - cnt_t'(1))
                                              : addr_t'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    assign key_hit  = (rd_key_reg == key_reg);
    assign pair_hit = key_hit && (rd_val_reg == val_reg);

    assign s_axis_tready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        status_next = status_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        wr_en       = 1'b0;
        wr_addr     = addr_t'(idx_reg);
        wr_key      = rd_key_reg;
        wr_val      = rd_val_reg;
        out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next   = s_axis_tdata[1:0];
                    key_next   = s_axis_tdata[33:2];
                    val_next   = s_axis_tdata[65:34];
                    idx_next   = '0;
                    found_next = '0;
                    v1_next    = '0;
                    v2_next    = '0;
                    if (s_axis_tdata[1:0] == ACT_REMOVE_PAIR)
                        status_next = ST_MISS;
                    else
                        status_next = ST_DONE;
                    if (s_axis_tdata[1:0] == ACT_ADD && at_full)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_FINISH;
                    end
                    else
                        state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (idx_reg >= count_reg)
                    state_next = S_FINISH;
                else
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_READ;
                unique case (act_reg)
                    ACT_ADD:
                    begin
                        idx_next = idx_reg + cnt_t'(1);
                        if (key_hit)
                        begin
                            if (found_reg == 2'd1)
                            begin
                                status_next = ST_MISS;
                                state_next  = S_FINISH;
                            end
                            found_next = found_reg + 2'd1;
                        end
                    end
                    ACT_SEARCH:
                    begin
                        idx_next = idx_reg + cnt_t'(1);
                        if (key_hit)
                        begin
                            if (found_reg == 2'd0)
                                v1_next = rd_val_reg;
                            else
                            begin
                                v2_next    = rd_val_reg;
                                state_next = S_FINISH;
                            end
                            found_next = found_reg + 2'd1;
                        end
                    end
                    ACT_REMOVE_PAIR:
                    begin
                        if (pair_hit)
                        begin
                            status_next = ST_DONE;
                            state_next  = S_MOVE_RD;
                        end
                        else
                            idx_next = idx_reg + cnt_t'(1);
                    end
                    ACT_REMOVE_KEY:
                    begin
                        if (key_hit)
                        begin
                            if (found_reg == 2'd0)
                                v1_next = rd_val_reg;
                            else
                                v2_next = rd_val_reg;
                            found_next = found_reg + 2'd1;
                            state_next = S_MOVE_RD;
                        end
                        else
                            idx_next = idx_reg + cnt_t'(1);
                    end
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_MOVE_RD:
                state_next = S_MOVE_WR;
            S_MOVE_WR:
            begin
                // last entry fills the hole at idx
                wr_en      = 1'b1;
                count_next = count_reg - cnt_t'(1);
                if (act_reg == ACT_REMOVE_KEY && found_reg != 2'd2)
                    state_next = S_READ;
                else
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (act_reg == ACT_ADD && status_reg == ST_DONE)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = addr_t'(count_reg);
                    wr_key     = key_reg;
                    wr_val     = val_reg;
                    count_next = count_reg + cnt_t'(1);
                end
                if ((act_reg == ACT_SEARCH || act_reg == ACT_REMOVE_KEY)
                    && found_reg == 2'd0)
                    status_next = ST_MISS;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign fin_found_used = (act_reg == ACT_SEARCH) || (act_reg == ACT_REMOVE_KEY);
    assign fin_status     = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        act_reg    <= act_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        v1_reg     <= v1_next;
        v2_reg     <= v2_next;
        if (out_load)
        begin
            out_data_reg[1:0]   <= fin_status;
            out_data_reg[33:2]  <= v1_reg;
            out_data_reg[65:34] <= v2_reg;
            out_data_reg[67:66] <= fin_found_used ? found_reg : 2'd0;
            out_data_reg[72:68] <= 5'(count_reg);
            out_data_reg[73]    <= (count_reg == '0);
            out_data_reg[74]    <= at_full;
            out_data_reg[79:75] <= '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MAX_ENTRIES))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg == $past(count_reg)
             || count_reg == $past(count_reg) + cnt_t'(1)
             || count_reg == $past(count_reg) - cnt_t'(1)))
        else $error("entry count jumped");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while busy");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL |-> m_axis_tdata[74])
        else $error("full status without full flag");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[73] == (m_axis_tdata[72:68] == 5'd0)))
        else $error("empty flag disagrees with count");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !wr_en)
        else $error("table written while idle");

endmodule
